@@ rtl/core/wcds_pkg.sv @@
package wcds_pkg;

  typedef logic [2:0] func_t;
  typedef logic [1:0] run_state_t;
  typedef logic [2:0] cause_t;

  // event codes
  localparam func_t FUNC_LAUNCH_OK   = 3'd0;
  localparam func_t FUNC_LAUNCH_FAIL = 3'd1;
  localparam func_t FUNC_DISPATCH    = 3'd2;
  localparam func_t FUNC_IDLE        = 3'd3;
  localparam func_t FUNC_CLAIM       = 3'd4;
  localparam func_t FUNC_HEARTBEAT   = 3'd5;
  localparam func_t FUNC_SERVICE     = 3'd6;
  localparam func_t FUNC_STACK_CHECK = 3'd7;

  // run states
  localparam run_state_t ST_OFF  = 2'd0;
  localparam run_state_t ST_RUN  = 2'd1;
  localparam run_state_t ST_PARK = 2'd2;
  localparam run_state_t ST_DEAD = 2'd3;

  // death causes
  localparam cause_t CAUSE_NONE        = 3'd0;
  localparam cause_t CAUSE_NO_CLAIM    = 3'd1;
  localparam cause_t CAUSE_STALLED     = 3'd2;
  localparam cause_t CAUSE_STACK       = 3'd3;
  localparam cause_t CAUSE_NO_ANNOUNCE = 3'd4;

  localparam logic [15:0] STALL_LIMIT_RESET = 16'd2000;

  typedef struct packed {
    func_t       func;
    logic [31:0] grant_us;
    logic [31:0] now_ms;
    logic        stack_intact;
  } evt_t;

  typedef struct packed {
    run_state_t  run_state;
    logic        flash_ok;
    logic        killed;
    cause_t      cause;
    logic [31:0] skipped_total;
    logic [31:0] grant_budget;
  } rsp_t;

endpackage

@@ rtl/core/wcds_engine.sv @@
module wcds_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_data,
  input  logic           step,
  input  wcds_pkg::evt_t evt,
  output wcds_pkg::rsp_t result
);
  import wcds_pkg::*;

  logic [15:0] stall_limit;
  run_state_t  run_state, run_state_next;
  logic [31:0] grants_issued, grants_issued_next;
  logic [31:0] grants_taken, grants_taken_next;
  logic        worker_busy, worker_busy_next;
  logic        worker_ready, worker_ready_next;
  logic [31:0] skipped_count, skipped_count_next;
  logic [31:0] heartbeat_count, heartbeat_count_next;
  logic [31:0] last_heartbeat, last_heartbeat_next;
  logic [31:0] last_change_ms, last_change_ms_next;
  logic        watch_started, watch_started_next;
  logic [31:0] budget, budget_next;
  cause_t      cause, cause_next;
  logic        killed_next;
  logic        inactive, inactive_next;
  logic        grant_open;
  logic [31:0] elapsed;
  logic        flash_next;

  assign inactive   = (run_state == ST_OFF) || (run_state == ST_DEAD);
  assign grant_open = grants_issued != grants_taken;
  assign elapsed    = evt.now_ms - last_change_ms;

  always_comb begin
    run_state_next       = run_state;
    grants_issued_next   = grants_issued;
    grants_taken_next    = grants_taken;
    worker_busy_next     = worker_busy;
    worker_ready_next    = worker_ready;
    skipped_count_next   = skipped_count;
    heartbeat_count_next = heartbeat_count;
    last_heartbeat_next  = last_heartbeat;
    last_change_ms_next  = last_change_ms;
    watch_started_next   = watch_started;
    budget_next          = budget;
    cause_next           = cause;
    killed_next          = 1'b0;
    unique case (evt.func)
      FUNC_LAUNCH_OK: begin
        run_state_next = ST_RUN;
        cause_next     = CAUSE_NONE;
      end
      FUNC_LAUNCH_FAIL: begin
        run_state_next = ST_DEAD;
        cause_next     = CAUSE_NO_ANNOUNCE;
        killed_next    = 1'b1;
      end
      FUNC_DISPATCH: begin
        if (!inactive) begin
          if (worker_busy) begin
            skipped_count_next = skipped_count + 32'd1;
          end else begin
            budget_next        = evt.grant_us;
            grants_issued_next = grants_issued + 32'd1;
          end
        end
      end
      FUNC_IDLE: begin
        if (!inactive) begin
          worker_busy_next  = 1'b0;
          worker_ready_next = 1'b1;
          run_state_next    = ST_PARK;
        end
      end
      FUNC_CLAIM: begin
        if (run_state == ST_PARK && grant_open) begin
          grants_taken_next = grants_issued;
          worker_busy_next  = 1'b1;
          run_state_next    = ST_RUN;
        end
      end
      FUNC_HEARTBEAT: begin
        if (!inactive) heartbeat_count_next = heartbeat_count + 32'd1;
      end
      FUNC_SERVICE: begin
        if (!inactive) begin
          // parked with nothing pending, or first tick: re-arm only
          if ((run_state == ST_PARK && !grant_open) || !watch_started) begin
            last_heartbeat_next = heartbeat_count;
            last_change_ms_next = evt.now_ms;
            watch_started_next  = 1'b1;
          end else if (heartbeat_count != last_heartbeat) begin
            last_heartbeat_next = heartbeat_count;
            last_change_ms_next = evt.now_ms;
          end else if (elapsed > {16'd0, stall_limit}) begin
            run_state_next = ST_DEAD;
            cause_next     = grant_open ? CAUSE_NO_CLAIM : CAUSE_STALLED;
            killed_next    = 1'b1;
          end
        end
      end
      FUNC_STACK_CHECK: begin
        if (run_state == ST_RUN && !evt.stack_intact) begin
          run_state_next = ST_DEAD;
          cause_next     = CAUSE_STACK;
          killed_next    = 1'b1;
        end
      end
    endcase
  end

  assign inactive_next = (run_state_next == ST_OFF) || (run_state_next == ST_DEAD);

  always_comb begin
    if (inactive_next) begin
      flash_next = 1'b1;
    end else if (!worker_ready_next) begin
      flash_next = 1'b0;
    end else begin
      flash_next = (grants_issued_next == grants_taken_next) && !worker_busy_next;
    end
  end

  always_comb begin
    result.run_state     = run_state_next;
    result.flash_ok      = flash_next;
    result.killed        = killed_next;
    result.cause         = cause_next;
    result.skipped_total = skipped_count_next;
    result.grant_budget  = budget_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stall_limit <= STALL_LIMIT_RESET;
    end else if (cfg_we) begin
      stall_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_state       <= ST_OFF;
      grants_issued   <= '0;
      grants_taken    <= '0;
      worker_busy     <= 1'b0;
      worker_ready    <= 1'b0;
      skipped_count   <= '0;
      heartbeat_count <= '0;
      last_heartbeat  <= '0;
      last_change_ms  <= '0;
      watch_started   <= 1'b0;
      budget          <= '0;
      cause           <= CAUSE_NONE;
    end else if (step) begin
      run_state       <= run_state_next;
      grants_issued   <= grants_issued_next;
      grants_taken    <= grants_taken_next;
      worker_busy     <= worker_busy_next;
      worker_ready    <= worker_ready_next;
      skipped_count   <= skipped_count_next;
      heartbeat_count <= heartbeat_count_next;
      last_heartbeat  <= last_heartbeat_next;
      last_change_ms  <= last_change_ms_next;
      watch_started   <= watch_started_next;
      budget          <= budget_next;
      cause           <= cause_next;
    end
  end

`ifndef ASSERT_OFF
  a_kill_goes_dead: assert property (@(posedge clk) disable iff (rst)
    step && result.killed |=> run_state == ST_DEAD && cause != CAUSE_NONE)
    else $error("kill did not leave the worker dead with a cause");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(run_state) && $stable(grants_issued) && $stable(heartbeat_count))
    else $error("state moved without an event");

  a_taken_catches_up: assert property (@(posedge clk) disable iff (rst)
    step |=> grants_taken == $past(grants_taken) || grants_taken == $past(grants_issued))
    else $error("grant count taken jumped to an unexpected value");

  a_inactive_flash: assert property (@(posedge clk) disable iff (rst)
    step && (result.run_state == ST_OFF || result.run_state == ST_DEAD) |-> result.flash_ok)
    else $error("flash not reported safe while worker is inactive");
`endif

endmodule

@@ rtl/core/worker_core_dispatch_supervisor.sv @@
// Worker core supervisor: takes one event beat per clock and returns one result beat
// per event, in order. Each event is held in an input register, then applied to the
// supervisor state and the outcome captured in a result register, so a result beat
// is offered once its event has passed the input register and then the result
// register, and the block sustains one event per clock; it only stalls when the
// result register is held by rsp_ready low.
// stall_limit (cfg_data) is written when cfg_we is high and rst low, resets to 2000 ms.
module worker_core_dispatch_supervisor (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_data,
  input  logic           req_valid,
  output logic           req_ready,
  input  wcds_pkg::evt_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output wcds_pkg::rsp_t rsp
);
  import wcds_pkg::*;

  logic  evt_valid;
  evt_t  evt;
  logic  step;
  rsp_t  result;

  assign step      = evt_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !evt_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        evt_valid <= 1'b1;
      end else if (step) begin
        evt_valid <= 1'b0;
      end
      if (step) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) evt <= req;
    if (step) rsp <= result;
  end

  wcds_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .step     (step),
    .evt      (evt),
    .result   (result)
  );

endmodule
